// ----- hdl/msf_pkg.sv -----
// ----------------------------------------------------------------------------
// msf_pkg
// Shared types and constants of the maximal square finder.
// ----------------------------------------------------------------------------
package msf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int SIZE_W = 11;
    localparam int POS_W  = 10;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [POS_W-1:0]  t_pos;

    localparam t_size WIDTH_RESET = t_size'(MAX_WIDTH);
    localparam t_size SIZE_MAX    = t_size'(MAX_HEIGHT);
    localparam t_pos  ROW_LAST    = t_pos'(MAX_HEIGHT - 1);

    localparam logic REG_MAP_WIDTH = 1'b0;

    typedef struct packed {
        logic shift;
        t_pos tail_idx;
    } t_line_ctrl;

endpackage

// ----- hdl/msf_req_if.sv -----
// ----------------------------------------------------------------------------
// msf_req_if
// Request channel carrying one map cell.
// ----------------------------------------------------------------------------
interface msf_req_if;
    logic valid;
    logic ready;
    logic cell_empty;
    logic last_cell;

    modport source (output valid, output cell_empty, output last_cell, input ready);
    modport sink   (input valid, input cell_empty, input last_cell, output ready);
endinterface

// ----- hdl/msf_res_if.sv -----
// ----------------------------------------------------------------------------
// msf_res_if
// Result channel carrying the largest square of one map.
// ----------------------------------------------------------------------------
interface msf_res_if;
    import msf_pkg::*;
    logic  valid;
    logic  ready;
    t_size best_size;
    t_pos  best_row;
    t_pos  best_col;

    modport source (output valid, output best_size, output best_row, output best_col,
                    input ready);
    modport sink   (input valid, input best_size, input best_row, input best_col,
                    output ready);
endinterface

// ----- hdl/msf_cell.sv -----
// ----------------------------------------------------------------------------
// msf_cell
// One stage of the row line: holds one score and passes it to its left
// neighbour, or loads the new score when it is the tail of the line.
// ----------------------------------------------------------------------------
module msf_cell
    import msf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  logic  i_tail,
    input  t_size i_feed,
    input  t_size i_next,
    output t_size o_val
);

    t_size r_val;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_tail ? i_feed : i_next;
        end
    end

    assign o_val = r_val;

endmodule

// ----- hdl/msf_row_line.sv -----
// ----------------------------------------------------------------------------
// msf_row_line
// Chain of cells forming a row-long delay line of scores; the head cell
// always holds the score of the cell directly above the next map cell.
// ----------------------------------------------------------------------------
module msf_row_line
    import msf_pkg::*;
(
    input  logic       i_clk,
    input  t_line_ctrl i_ctrl,
    input  t_size      i_feed,
    output t_size      o_upper
);

    t_size w_val [MAX_WIDTH];

    for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_cell
        t_size w_next;
        if (g == MAX_WIDTH - 1) begin : g_end
            assign w_next = i_feed;
        end else begin : g_mid
            assign w_next = w_val[g+1];
        end
        msf_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(i_ctrl.shift),
            .i_tail (i_ctrl.tail_idx == t_pos'(g)),
            .i_feed (i_feed),
            .i_next (w_next),
            .o_val  (w_val[g])
        );
    end

    assign o_upper = w_val[0];

endmodule

// ----- hdl/maximal_square_finder.sv -----
// ----------------------------------------------------------------------------
// maximal_square_finder
// Largest empty square in a map streamed one cell per request.
//
// Map cells arrive on i_req in raster order, cell_empty marking a free cell
// and last_cell marking the final cell of the map. A cell can be taken in
// every cycle; the score of each cell is worked out in the cycle it is
// taken, from the head of a chain of cells that delays each score by one
// map row, so the rate is one cell per clock unless a stalled result holds it.
// On the request that carries last_cell the side, row and column of the
// first largest square are registered and offered on o_res in the next cycle;
// the block then starts a new map. While a result waits and o_res.ready is
// low, i_req.ready is held low, so a stalled receiver halts the cell stream
// until the result is taken. APB address 0 holds map_width; the user is to
// write it only between maps, which the block does not check. Reset clears
// positions, scores and the result flag and sets map_width to 1024; the row
// line needs no clearing as the first row never reads it.
// ----------------------------------------------------------------------------
module maximal_square_finder
    import msf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    msf_req_if.sink               i_req,
    msf_res_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_size r_map_width;
    t_pos  r_col, n_col;
    t_pos  r_row, n_row;
    t_size r_left, n_left;
    t_size r_diag, n_diag;
    t_size r_best_size, n_best_size;
    t_pos  r_best_row, n_best_row;
    t_pos  r_best_col, n_best_col;
    logic  r_out_valid;
    t_size r_res_size;
    t_pos  r_res_row;
    t_pos  r_res_col;

    t_size      w_eff_width;
    t_pos       w_last_col;
    t_pos       w_col;
    t_size      w_upper;
    t_size      w_least;
    t_size      w_score;
    logic       w_better;
    logic       w_accept;
    t_line_ctrl w_line_ctrl;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width <= WIDTH_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MAP_WIDTH)) begin
            r_map_width <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAP_WIDTH: prdata = APB_DATA_W'(r_map_width);
            default:       prdata = '0;
        endcase
    end

    // Cell scoring.
    always_comb begin
        if (r_map_width == '0) begin
            w_eff_width = t_size'(1);
        end else if (r_map_width > t_size'(MAX_WIDTH)) begin
            w_eff_width = t_size'(MAX_WIDTH);
        end else begin
            w_eff_width = r_map_width;
        end
        w_last_col = t_pos'(w_eff_width - t_size'(1));
        w_col      = (r_col > w_last_col) ? w_last_col : r_col;

        w_least = w_upper;
        if (r_left < w_least) begin
            w_least = r_left;
        end
        if (r_diag < w_least) begin
            w_least = r_diag;
        end

        if (!i_req.cell_empty) begin
            w_score = '0;
        end else if ((r_row == '0) || (w_col == '0)) begin
            w_score = t_size'(1);
        end else if (w_least >= SIZE_MAX) begin
            w_score = SIZE_MAX;
        end else begin
            w_score = w_least + t_size'(1);
        end
        w_better = (w_score > r_best_size);
    end

    assign w_accept             = i_req.valid && i_req.ready;
    assign i_req.ready          = !r_out_valid || o_res.ready;
    assign w_line_ctrl.shift    = w_accept;
    assign w_line_ctrl.tail_idx = w_last_col;

    msf_row_line u_row_line (
        .i_clk  (i_clk),
        .i_ctrl (w_line_ctrl),
        .i_feed (w_score),
        .o_upper(w_upper)
    );

    always_comb begin
        n_best_size = w_better ? w_score : r_best_size;
        n_best_row  = w_better ? r_row   : r_best_row;
        n_best_col  = w_better ? w_col   : r_best_col;
        if (w_col == w_last_col) begin
            n_col  = '0;
            n_left = '0;
            n_diag = '0;
            n_row  = (r_row == ROW_LAST) ? r_row : r_row + t_pos'(1);
        end else begin
            n_col  = w_col + t_pos'(1);
            n_left = w_score;
            n_diag = w_upper;
            n_row  = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && i_req.last_cell) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                if (i_req.last_cell) begin
                    r_col       <= '0;
                    r_row       <= '0;
                    r_left      <= '0;
                    r_diag      <= '0;
                    r_best_size <= '0;
                    r_best_row  <= '0;
                    r_best_col  <= '0;
                end else begin
                    r_col       <= n_col;
                    r_row       <= n_row;
                    r_left      <= n_left;
                    r_diag      <= n_diag;
                    r_best_size <= n_best_size;
                    r_best_row  <= n_best_row;
                    r_best_col  <= n_best_col;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_req.last_cell) begin
            r_res_size <= n_best_size;
            r_res_row  <= n_best_row;
            r_res_col  <= n_best_col;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.best_size = r_res_size;
    assign o_res.best_row  = r_res_row;
    assign o_res.best_col  = r_res_col;

    // A final cell always leaves a result waiting.
    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.last_cell) |=> r_out_valid)
        else $error("no result after the final cell");

    // An empty cell inside a map always leaves a nonzero best score.
    a_best_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_req.last_cell && i_req.cell_empty) |=> (r_best_size != '0))
        else $error("best score lost after an empty cell");

    // The end of a row returns the column to zero.
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_req.last_cell && (w_col == w_last_col)) |=> (r_col == '0))
        else $error("column not reset at the end of a row");

endmodule

// ----- sim/maximal_square_finder_tb.sv -----
// ----------------------------------------------------------------------------
// maximal_square_finder_tb
// Self-checking testbench of the maximal square finder.
//
// Maps are streamed cell by cell on the request channel. A short table of
// hand-made maps covers the reset width, maps with no free cell, obstacles
// inside a square, ties and widths outside the legal range. Random maps
// follow, with random widths and obstacle densities, maps cut short and a
// long stall of the result channel that fills the block. Table maps are
// matched to listed squares, the others to a behavioural model of the scoring.
// The map width is written over APB between maps and read back.
// ----------------------------------------------------------------------------
module maximal_square_finder_tb
    import msf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CELLS   = 1078;
    localparam int HOLD_CYCLES    = 120;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [APB_ADDR_W-1:0] MAP_WIDTH_ADDR = APB_ADDR_W'(4 * int'(REG_MAP_WIDTH));

    typedef struct packed {
        t_size size;
        t_pos  row;
        t_pos  col;
    } t_square;

    typedef struct packed {
        logic    set_width;
        t_size   width;
        logic    cell_empty;
        logic    last_cell;
        logic    typed;
        t_square square;
    } t_map_cell;

    localparam t_map_cell MAP_TABLE [22] = '{
        '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, '{11'd1, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b0, 1'b1, 1'b1, '{11'd0, 10'd0, 10'd0}},
        '{1'b1, 11'd3,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, '{11'd2, 10'd1, 10'd1}},
        '{1'b1, 11'd2,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, '{11'd2, 10'd1, 10'd1}},
        '{1'b1, 11'd0,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, '{11'd1, 10'd0, 10'd0}},
        '{1'b1, 11'd2047, 1'b0, 1'b0, 1'b0, '{11'd0, 10'd0, 10'd0}},
        '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, '{11'd1, 10'd0, 10'd1}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    msf_req_if req_chan ();
    msf_res_if res_chan ();

    maximal_square_finder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_chan),
        .o_res   (res_chan),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_size   upper_scores [MAX_WIDTH];
    t_size   left_score;
    t_size   diag_score;
    t_pos    col_pos;
    t_pos    row_pos;
    t_size   top_size;
    t_pos    top_row;
    t_pos    top_col;
    t_size   width_reg;

    t_square pending_squares [$];
    int      error_count;
    int      cells_sent;
    int      maps_sent;
    int      width_writes;
    int      squares_checked;
    bit      no_idle;
    bit      hold_pending;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void restart_map();
        left_score = '0;
        diag_score = '0;
        col_pos    = '0;
        row_pos    = '0;
        top_size   = '0;
        top_row    = '0;
        top_col    = '0;
    endfunction

    function automatic bit score_cell(input logic empty, input logic last, output t_square sq);
        int unsigned w;
        int unsigned c;
        int unsigned up;
        int unsigned m;
        int unsigned score;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        c = col_pos;
        if (c >= w) c = w - 1;
        up = upper_scores[c];
        if (!empty) begin
            score = 0;
        end else if (row_pos == 0 || c == 0) begin
            score = 1;
        end else begin
            m = up;
            if (left_score < m) m = left_score;
            if (diag_score < m) m = diag_score;
            score = m + 1;
            if (score > MAX_HEIGHT) score = MAX_HEIGHT;
        end
        upper_scores[c] = t_size'(score);
        if (score > top_size) begin
            top_size = t_size'(score);
            top_row  = row_pos;
            top_col  = t_pos'(c);
        end
        sq = '0;
        if (last) begin
            sq = '{top_size, top_row, top_col};
            restart_map();
            return 1'b1;
        end
        if (c + 1 >= w) begin
            col_pos    = '0;
            left_score = '0;
            diag_score = '0;
            if (row_pos + 1 < MAX_HEIGHT) row_pos = row_pos + 1'b1;
        end else begin
            col_pos    = t_pos'(c + 1);
            left_score = t_size'(score);
            diag_score = t_size'(up);
        end
        return 1'b0;
    endfunction

    task automatic send_cell(input logic empty, input logic last, input logic typed,
                             input t_square typed_sq);
        int      gap;
        t_square sq;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_chan.valid      <= 1'b1;
        req_chan.cell_empty <= empty;
        req_chan.last_cell  <= last;
        do @(posedge i_clk); while (!req_chan.ready);
        cells_sent++;
        if (score_cell(empty, last, sq)) begin
            pending_squares.push_back(typed ? typed_sq : sq);
            maps_sent++;
        end
    endtask

    task automatic drain_results();
        req_chan.valid <= 1'b0;
        while (pending_squares.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_map_width(input t_size value);
        logic [APB_DATA_W-1:0] readback;
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAP_WIDTH_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        width_reg = value;
        width_writes++;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DATA_W'(value)) begin
            $error("map_width: expected %0d, got %0d", value, readback);
            error_count++;
        end
    endtask

    initial begin : stimulus
        int      random_cells;
        int      total;
        int      pct;
        int      eff;
        int      sel;
        t_size   w;
        t_square none;
        none         = '0;
        random_cells = 0;
        error_count  = 0;
        cells_sent   = 0;
        maps_sent    = 0;
        width_writes = 0;
        no_idle      = 1'b0;
        hold_pending = 1'b0;
        foreach (upper_scores[i]) upper_scores[i] = '0;
        restart_map();
        width_reg = WIDTH_RESET;

        i_rst_n             <= 1'b0;
        req_chan.valid      <= 1'b0;
        req_chan.cell_empty <= 1'b0;
        req_chan.last_cell  <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < $size(MAP_TABLE); i++) begin
            if (MAP_TABLE[i].set_width) set_map_width(MAP_TABLE[i].width);
            send_cell(MAP_TABLE[i].cell_empty, MAP_TABLE[i].last_cell,
                      MAP_TABLE[i].typed, MAP_TABLE[i].square);
        end

        // The result channel is held off while single-cell maps keep coming.
        hold_pending = 1'b1;
        no_idle      = 1'b1;
        for (int k = 0; k < 14; k++) begin
            send_cell(1'($urandom_range(0, 1)), 1'b1, 1'b0, none);
            random_cells++;
        end

        while (random_cells < RANDOM_CELLS) begin
            sel = $urandom_range(0, 19);
            case (sel)
                0:       w = 11'd0;
                1:       w = 11'd2047;
                2:       w = t_size'(MAX_WIDTH);
                3, 4:    w = t_size'($urandom_range(9, 40));
                default: w = t_size'($urandom_range(1, 8));
            endcase
            if (w != width_reg) set_map_width(w);
            eff = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : int'(w));
            total = eff * $urandom_range(1, 6);
            if (eff >= 64) total = $urandom_range(1, 40);
            if ($urandom_range(0, 7) == 0) total = $urandom_range(1, total);
            if (total > RANDOM_CELLS - random_cells) total = RANDOM_CELLS - random_cells;
            case ($urandom_range(0, 3))
                0:       pct = 50;
                1:       pct = 85;
                2:       pct = 97;
                default: pct = $urandom_range(0, 100);
            endcase
            no_idle = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < total; k++) begin
                send_cell($urandom_range(0, 99) < pct, k == total - 1, 1'b0, none);
                random_cells++;
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d maps (%0d cells) under %0d width settings, including widths 0,",
                 squares_checked, cells_sent, width_writes);
        $display("2047 and 1024, maps cut short and a long result stall.");
        if (error_count == 0) begin
            $display("maximal_square_finder_tb: PASS");
        end else begin
            $display("maximal_square_finder_tb: FAIL");
        end
        $finish;
    end

    initial begin : result_check
        int      stall;
        t_square want;
        squares_checked = 0;
        res_chan.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (hold_pending) begin
                stall        = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            res_chan.ready <= (stall == 0);
            do @(posedge i_clk); while (!res_chan.valid);
            if (stall > 0) begin
                repeat (stall - 1) @(posedge i_clk);
                res_chan.ready <= 1'b1;
                do @(posedge i_clk); while (!res_chan.valid);
            end
            squares_checked++;
            if (pending_squares.size() == 0) begin
                $error("unexpected result: best_size %0d best_row %0d best_col %0d",
                       res_chan.best_size, res_chan.best_row, res_chan.best_col);
                error_count++;
            end else begin
                want = pending_squares.pop_front();
                if (res_chan.best_size !== want.size) begin
                    $error("best_size: expected %0d, got %0d", want.size, res_chan.best_size);
                    error_count++;
                end
                if (res_chan.best_row !== want.row) begin
                    $error("best_row: expected %0d, got %0d", want.row, res_chan.best_row);
                    error_count++;
                end
                if (res_chan.best_col !== want.col) begin
                    $error("best_col: expected %0d, got %0d", want.col, res_chan.best_col);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_chan.valid && req_chan.ready) || (res_chan.valid && res_chan.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timed out after %0d cycles without a transfer.", quiet_cycles);
                $display("maximal_square_finder_tb: FAIL");
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
hdl/msf_pkg.sv
hdl/msf_req_if.sv
hdl/msf_res_if.sv
hdl/msf_cell.sv
hdl/msf_row_line.sv
hdl/maximal_square_finder.sv
sim/maximal_square_finder_tb.sv
